// ----- rtl/core/fmd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmd_pkg
// Types and constants shared by the framed message deframer files.
// ----------------------------------------------------------------------------
package fmd_pkg;

	localparam int HEADER_BYTES = 24;
	localparam int POS_W        = 5;
	localparam int CFG_IDX_W    = 8;
	localparam int CFG_DATA_W   = 32;

	// magic bytes, first byte in the low lane
	localparam logic [31:0] HDR_MAGIC = 32'h5043_4E4D;

	localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_VERSION = 8'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAYLOAD      = 8'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_LOWEST      = 8'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_TYPE_HIGHEST     = 8'd3;

	localparam logic [15:0] RST_EXPECTED_VERSION = 16'd1;
	localparam logic [31:0] RST_MAX_PAYLOAD      = 32'd1048576;
	localparam logic [7:0]  RST_TYPE_LOWEST      = 8'd0;
	localparam logic [7:0]  RST_TYPE_HIGHEST     = 8'd255;

	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	localparam logic [2:0] ERR_MAGIC   = 3'd0;
	localparam logic [2:0] ERR_VERSION = 3'd1;
	localparam logic [2:0] ERR_TYPE    = 3'd2;
	localparam logic [2:0] ERR_LENGTH  = 3'd3;
	localparam logic [2:0] ERR_CHUNK   = 3'd4;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_ERROR   = 2'd2
	} phase_t;

	typedef struct packed {
		logic [15:0] expected_version;
		logic [31:0] max_payload;
		logic [7:0]  type_lowest;
		logic [7:0]  type_highest;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
	} stage_t;

endpackage
`default_nettype wire

// ----- rtl/core/fmd_byte_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmd_byte_if
// Byte stream channel with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fmd_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/fmd_result_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmd_result_if
// Result channel carrying decoded header, payload byte or error.
// ----------------------------------------------------------------------------
interface fmd_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  frame_type;
	logic [7:0]  frame_flags;
	logic [31:0] request_id;
	logic [31:0] chunk_index;
	logic [31:0] chunk_count;
	logic [31:0] payload_length;
	logic [7:0]  data_byte;
	logic        last;
	logic [2:0]  error_code;

	modport source (
		output valid, output kind, output frame_type, output frame_flags,
		output request_id, output chunk_index, output chunk_count,
		output payload_length, output data_byte, output last, output error_code,
		input ready
	);
	modport sink (
		input valid, input kind, input frame_type, input frame_flags,
		input request_id, input chunk_index, input chunk_count,
		input payload_length, input data_byte, input last, input error_code,
		output ready
	);
endinterface
`default_nettype wire

// ----- rtl/core/fmd_cfg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmd_cfg_if
// Register write channel: index and data with valid/ready handshake.
// ----------------------------------------------------------------------------
interface fmd_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [fmd_pkg::CFG_IDX_W-1:0]   index;
	logic [fmd_pkg::CFG_DATA_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/fmd_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmd_cfg_regs
// Configuration register file; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module fmd_cfg_regs (
	input  wire logic         clk,
	input  wire logic         arst_n,
	fmd_cfg_if.sink           cfg,
	output fmd_pkg::cfg_t     regs
);

	fmd_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.expected_version <= fmd_pkg::RST_EXPECTED_VERSION;
			regs_q.max_payload      <= fmd_pkg::RST_MAX_PAYLOAD;
			regs_q.type_lowest      <= fmd_pkg::RST_TYPE_LOWEST;
			regs_q.type_highest     <= fmd_pkg::RST_TYPE_HIGHEST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				fmd_pkg::CFG_EXPECTED_VERSION: regs_q.expected_version <= cfg.data[15:0];
				fmd_pkg::CFG_MAX_PAYLOAD:      regs_q.max_payload      <= cfg.data[31:0];
				fmd_pkg::CFG_TYPE_LOWEST:      regs_q.type_lowest      <= cfg.data[7:0];
				fmd_pkg::CFG_TYPE_HIGHEST:     regs_q.type_highest     <= cfg.data[7:0];
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/fmd_in_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmd_in_stage
// Input register for the byte stream; refills in the cycle it drains.
// ----------------------------------------------------------------------------
module fmd_in_stage (
	input  wire logic         clk,
	input  wire logic         arst_n,
	fmd_byte_if.sink          rx,
	input  wire logic         advance,
	output fmd_pkg::stage_t   stage
);

	logic       valid_s1;
	logic [7:0] byte_s1;

	assign rx.ready = !valid_s1 || advance;
	assign stage    = {valid_s1, byte_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.in_byte;
		end
	end

endmodule
`default_nettype wire

// ----- rtl/core/fmd_decode.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fmd_decode
// Frame state, header store, header checks and the result register.
// ----------------------------------------------------------------------------
module fmd_decode (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire fmd_pkg::stage_t   stage,
	input  wire fmd_pkg::cfg_t     regs,
	output logic                   advance,
	fmd_result_if.source           res
);

	fmd_pkg::phase_t            phase_q, phase_d;
	logic [fmd_pkg::POS_W-1:0]  pos_q, pos_d;
	logic [31:0]                remain_q, remain_d;
	logic [7:0]                 store_q [fmd_pkg::HEADER_BYTES];
	logic [7:0]                 hdr [fmd_pkg::HEADER_BYTES];

	logic                       out_valid_q;
	logic [1:0]                 kind_q;
	logic [7:0]                 type_q, flags_q, data_q;
	logic [31:0]                req_q, cidx_q, ccnt_q, len_q;
	logic                       last_q;
	logic [2:0]                 err_q;

	logic                       take;
	logic                       hdr_done;
	logic                       produce;
	logic [1:0]                 kind_d;
	logic [7:0]                 data_d;
	logic                       last_d;
	logic [2:0]                 err_d;
	logic                       bad;
	logic [31:0]                magic, req, len, cidx, ccnt, remain_dec;
	logic [15:0]                version;

	assign advance = !out_valid_q || res.ready;
	assign take    = stage.valid && advance;

	// current byte completes the header in place of its last entry
	always_comb begin
		for (int i = 0; i < fmd_pkg::HEADER_BYTES; i++) begin
			hdr[i] = store_q[i];
		end
		if (pos_q == fmd_pkg::POS_W'(fmd_pkg::HEADER_BYTES - 1)) begin
			hdr[fmd_pkg::HEADER_BYTES-1] = stage.data;
		end
	end

	assign magic   = {hdr[3], hdr[2], hdr[1], hdr[0]};
	assign version = {hdr[5], hdr[4]};
	assign req     = {hdr[11], hdr[10], hdr[9], hdr[8]};
	assign len     = {hdr[15], hdr[14], hdr[13], hdr[12]};
	assign cidx    = {hdr[19], hdr[18], hdr[17], hdr[16]};
	assign ccnt    = {hdr[23], hdr[22], hdr[21], hdr[20]};

	assign remain_dec = remain_q - {31'd0, (remain_q != 32'd0)};
	assign hdr_done   = (pos_q == fmd_pkg::POS_W'(fmd_pkg::HEADER_BYTES - 1));

	always_comb begin
		bad = 1'b1;
		if (magic != fmd_pkg::HDR_MAGIC) begin
			err_d = fmd_pkg::ERR_MAGIC;
		end else if (version != regs.expected_version) begin
			err_d = fmd_pkg::ERR_VERSION;
		end else if (hdr[6] < regs.type_lowest || hdr[6] > regs.type_highest) begin
			err_d = fmd_pkg::ERR_TYPE;
		end else if (len > regs.max_payload) begin
			err_d = fmd_pkg::ERR_LENGTH;
		end else if (ccnt == 32'd0 || cidx >= ccnt) begin
			err_d = fmd_pkg::ERR_CHUNK;
		end else begin
			err_d = fmd_pkg::ERR_MAGIC;
			bad   = 1'b0;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		remain_d = remain_q;
		produce  = 1'b0;
		kind_d   = fmd_pkg::KIND_HEADER;
		data_d   = 8'd0;
		last_d   = 1'b0;
		unique case (phase_q)
			fmd_pkg::PH_PAYLOAD: begin
				produce  = 1'b1;
				kind_d   = fmd_pkg::KIND_PAYLOAD;
				data_d   = stage.data;
				remain_d = remain_dec;
				if (remain_dec == 32'd0) begin
					last_d  = 1'b1;
					phase_d = fmd_pkg::PH_HEADER;
					pos_d   = '0;
				end
			end
			fmd_pkg::PH_HEADER: begin
				if (hdr_done) begin
					produce = 1'b1;
					pos_d   = '0;
					if (bad) begin
						kind_d  = fmd_pkg::KIND_ERROR;
						phase_d = fmd_pkg::PH_ERROR;
					end else if (len == 32'd0) begin
						last_d  = 1'b1;
					end else begin
						remain_d = len;
						phase_d  = fmd_pkg::PH_PAYLOAD;
					end
				end else begin
					pos_d = fmd_pkg::POS_W'(pos_q + 1'b1);
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= fmd_pkg::PH_HEADER;
			pos_q       <= '0;
			remain_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				phase_q  <= phase_d;
				pos_q    <= pos_d;
				remain_q <= remain_d;
			end
			if (advance) begin
				out_valid_q <= take && produce;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && phase_q == fmd_pkg::PH_HEADER) begin
			store_q[pos_q] <= stage.data;
		end
	end

	always_ff @(posedge clk) begin
		if (take && produce) begin
			kind_q  <= kind_d;
			type_q  <= hdr[6];
			flags_q <= hdr[7];
			req_q   <= req;
			cidx_q  <= cidx;
			ccnt_q  <= ccnt;
			len_q   <= len;
			data_q  <= data_d;
			last_q  <= last_d;
			err_q   <= (kind_d == fmd_pkg::KIND_ERROR) ? err_d : fmd_pkg::ERR_MAGIC;
		end
	end

	assign res.valid          = out_valid_q;
	assign res.kind           = kind_q;
	assign res.frame_type     = type_q;
	assign res.frame_flags    = flags_q;
	assign res.request_id     = req_q;
	assign res.chunk_index    = cidx_q;
	assign res.chunk_count    = ccnt_q;
	assign res.payload_length = len_q;
	assign res.data_byte      = data_q;
	assign res.last           = last_q;
	assign res.error_code     = err_q;

endmodule
`default_nettype wire

// ----- rtl/core/framed_message_deframer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// framed_message_deframer
// Collects a 24-byte little-endian header, checks it, then passes the payload
// through one byte per result; errors are sticky until reset.
//
//   channel  role    transaction
//   rx       sink    one stream byte
//   res      source  header, payload byte or error result
//   cfg      sink    one register write (index, data)
//
// One byte enters per clock while res is not stalled; rx reaches res via
// the input register and the result register. The rate is set by the single
// decode stage between them; frame state updates there once per byte.
// A stall on res holds the result register and backs up through the input
// register to rx.ready; while res is full every byte waits, with or without
// a result.
// Reset clears frame state and loads register defaults; no clearing pass.
// ----------------------------------------------------------------------------
module framed_message_deframer (
	input  wire logic     clk,
	input  wire logic     arst_n,
	fmd_byte_if.sink      rx,
	fmd_result_if.source  res,
	fmd_cfg_if.sink       cfg
);

	fmd_pkg::cfg_t   regs;
	fmd_pkg::stage_t stage;
	logic            advance;

	fmd_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	fmd_in_stage u_in (
		.clk     (clk),
		.arst_n  (arst_n),
		.rx      (rx),
		.advance (advance),
		.stage   (stage)
	);

	fmd_decode u_dec (
		.clk     (clk),
		.arst_n  (arst_n),
		.stage   (stage),
		.regs    (regs),
		.advance (advance),
		.res     (res)
	);

endmodule
`default_nettype wire
